FILE: src/emulated_cpu_memory_map_defines.svh
// Assertion macros used by the checker of the emulated memory map.
// Depends on nothing; included by the checker only.
`ifndef EMULATED_CPU_MEMORY_MAP_DEFINES_SVH
`define EMULATED_CPU_MEMORY_MAP_DEFINES_SVH

// Concurrent check that is switched off while reset is asserted.
`define ECMM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("memory map port check failed");

// Concurrent check that also runs during reset.
`define ECMM_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("memory map reset check failed");

`endif

FILE: src/ecmm_pkg.sv
// Types and constants of the emulated processor memory map.
// Depends on nothing; used by every module of the block but ecmm_ram.
`timescale 1ns / 1ps

package ecmm_pkg;

    // Access operations carried in each input word.
    typedef enum logic [1:0] {
        OP_DATA_READ  = 2'd0,
        OP_DATA_WRITE = 2'd1,
        OP_FETCH      = 2'd2,
        OP_LOAD       = 2'd3
    } op_t;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_INSTR_BASE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DATA_BASE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GETC_BASE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PUTC_BASE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PORT_WINDOW = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [31:0] RST_INSTR_BASE  = 32'h1000_0000;
    localparam logic [31:0] RST_DATA_BASE   = 32'h2000_0000;
    localparam logic [31:0] RST_GETC_BASE   = 32'h3000_0000;
    localparam logic [31:0] RST_PUTC_BASE   = 32'h3000_0004;
    localparam logic [4:0]  RST_PORT_WINDOW = 5'd4;

    // Byte counts used for the normalized access length.
    localparam logic [2:0] COUNT_ONE  = 3'd1;
    localparam logic [2:0] COUNT_WORD = 3'd4;

    // Outcome of one access, decided at issue and finished at response.
    typedef enum logic [2:0] {
        ACC_FAULT    = 3'd0,
        ACC_CON_IN   = 3'd1,
        ACC_CON_END  = 3'd2,
        ACC_CON_OUT  = 3'd3,
        ACC_DATA_RD  = 3'd4,
        ACC_INSTR_RD = 3'd5,
        ACC_QUIET    = 3'd6
    } acc_kind_t;

    typedef struct packed {
        logic [31:0] instr_base;
        logic [31:0] data_base;
        logic [31:0] getc_base;
        logic [31:0] putc_base;
        logic [4:0]  port_window;
    } cfg_t;

    typedef struct packed {
        op_t         operation;
        logic [31:0] address;
        logic [2:0]  byte_count;
        logic [31:0] write_data;
        logic [7:0]  console_in_byte;
        logic        console_in_end;
    } mem_req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        fault;
        logic        console_in_taken;
        logic        console_out_valid;
        logic [7:0]  console_out_byte;
    } mem_rsp_t;

    // Control handed from the issue stage to the response stage.
    typedef struct packed {
        acc_kind_t   kind;
        logic [1:0]  lane;
        logic [2:0]  count;
        logic [7:0]  con_byte;
    } rsp_ctl_t;

endpackage

FILE: src/ecmm_ram.sv
// Generic single-port RAM with a registered read.
// Depends on nothing; every byte bank of the block is one instance.
`timescale 1ns / 1ps

module ecmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port share one address.
    always_ff @(posedge clk) begin
        if (we) begin
            mem_array[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_array[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/ecmm_decode.sv
// Issue-stage decode: length normalization, region and window checks,
// bank rows, write lanes and byte steering. Depends on ecmm_pkg.
`timescale 1ns / 1ps

module ecmm_decode #(
    parameter int INSTR_BYTES_LOG2 = 16,
    parameter int DATA_BYTES_LOG2  = 16
) (
    input  ecmm_pkg::mem_req_t           req,
    input  ecmm_pkg::cfg_t               cfg,
    output logic [INSTR_BYTES_LOG2-3:0]  instr_row [4],
    output logic [DATA_BYTES_LOG2-3:0]   data_row  [4],
    output logic [7:0]                   bank_byte [4],
    output logic [3:0]                   instr_we,
    output logic [3:0]                   data_we,
    output logic                         instr_re,
    output logic                         data_re,
    output ecmm_pkg::rsp_ctl_t           ctl
);

    localparam int IROW_W = INSTR_BYTES_LOG2 - 2;
    localparam int DROW_W = DATA_BYTES_LOG2 - 2;
    localparam logic [32:0] INSTR_SIZE = 33'd1 << INSTR_BYTES_LOG2;
    localparam logic [32:0] DATA_SIZE  = 33'd1 << DATA_BYTES_LOG2;

    logic [2:0]  count;
    logic [32:0] span_end;
    logic [32:0] getc_end;
    logic [32:0] putc_end;
    logic        touch_in;
    logic        touch_out;
    logic        in_data;
    logic        in_instr;
    logic [31:0] ioff;
    logic [31:0] doff;
    logic [IROW_W-1:0] irow;
    logic [DROW_W-1:0] drow;
    logic [1:0]  ilane;
    logic [1:0]  dlane;
    logic [1:0]  wlane;
    logic [3:0]  lane_mask;

    // Normalize the access length.
    always_comb begin
        if (req.operation == ecmm_pkg::OP_FETCH || req.operation == ecmm_pkg::OP_LOAD) begin
            count = ecmm_pkg::COUNT_WORD;
        end else if (req.byte_count == 3'd0) begin
            count = ecmm_pkg::COUNT_ONE;
        end else if (req.byte_count > ecmm_pkg::COUNT_WORD) begin
            count = ecmm_pkg::COUNT_WORD;
        end else begin
            count = req.byte_count;
        end
    end

    // Span and window checks, computed without wrap at the top of the space.
    assign span_end  = {1'b0, req.address} + 33'(count);
    assign getc_end  = {1'b0, cfg.getc_base} + 33'(cfg.port_window);
    assign putc_end  = {1'b0, cfg.putc_base} + 33'(cfg.port_window);
    assign touch_in  = (cfg.port_window != 5'd0) && ({1'b0, req.address} < getc_end)
                       && ({1'b0, cfg.getc_base} < span_end);
    assign touch_out = (cfg.port_window != 5'd0) && ({1'b0, req.address} < putc_end)
                       && ({1'b0, cfg.putc_base} < span_end);
    assign in_data   = (req.address >= cfg.data_base)
                       && (span_end <= {1'b0, cfg.data_base} + DATA_SIZE);
    assign in_instr  = (req.address >= cfg.instr_base)
                       && (span_end <= {1'b0, cfg.instr_base} + INSTR_SIZE);

    // Region offsets split into a starting row and a starting byte lane.
    assign ioff  = req.address - cfg.instr_base;
    assign doff  = req.address - cfg.data_base;
    assign irow  = ioff[INSTR_BYTES_LOG2-1:2];
    assign drow  = doff[DATA_BYTES_LOG2-1:2];
    assign ilane = ioff[1:0];
    assign dlane = doff[1:0];
    assign wlane = (req.operation == ecmm_pkg::OP_LOAD) ? ilane : dlane;

    // Banks below the starting lane hold bytes of the following row.
    always_comb begin
        logic [1:0] pos;
        logic [1:0] shift_k;
        for (int b = 0; b < 4; b++) begin
            instr_row[b] = (2'(b) >= ilane) ? irow : irow + IROW_W'(1);
            data_row[b]  = (2'(b) >= dlane) ? drow : drow + DROW_W'(1);
            pos          = 2'(b) - wlane;
            shift_k      = 2'(count - 3'd1 - {1'b0, pos});
            lane_mask[b] = ({1'b0, pos} < count);
            bank_byte[b] = req.write_data[{shift_k, 3'b000} +: 8];
        end
    end

    // Access outcome and store enables.
    always_comb begin
        instr_we     = 4'b0000;
        data_we      = 4'b0000;
        instr_re     = 1'b0;
        data_re      = 1'b0;
        ctl.kind     = ecmm_pkg::ACC_FAULT;
        ctl.lane     = dlane;
        ctl.count    = count;
        ctl.con_byte = req.console_in_byte;
        unique case (req.operation)
            ecmm_pkg::OP_DATA_READ: begin
                if (touch_in) begin
                    ctl.kind = req.console_in_end ? ecmm_pkg::ACC_CON_END
                                                  : ecmm_pkg::ACC_CON_IN;
                end else if (in_data) begin
                    ctl.kind = ecmm_pkg::ACC_DATA_RD;
                    data_re  = 1'b1;
                end
            end
            ecmm_pkg::OP_DATA_WRITE: begin
                ctl.con_byte = req.write_data[7:0];
                if (touch_out) begin
                    ctl.kind = ecmm_pkg::ACC_CON_OUT;
                end else if (in_data) begin
                    ctl.kind = ecmm_pkg::ACC_QUIET;
                    data_we  = lane_mask;
                end
            end
            ecmm_pkg::OP_FETCH: begin
                ctl.lane = ilane;
                if (in_instr) begin
                    ctl.kind = ecmm_pkg::ACC_INSTR_RD;
                    instr_re = 1'b1;
                end
            end
            ecmm_pkg::OP_LOAD: begin
                ctl.lane = ilane;
                if (in_instr) begin
                    ctl.kind = ecmm_pkg::ACC_QUIET;
                    instr_we = lane_mask;
                end
            end
            default: begin
                ctl.kind = ecmm_pkg::ACC_FAULT;
            end
        endcase
    end

endmodule

FILE: src/ecmm_assemble.sv
// Response-stage assembly: gathers the bank read bytes in big-endian
// order and forms the result word. Depends on ecmm_pkg.
`timescale 1ns / 1ps

module ecmm_assemble (
    input  ecmm_pkg::rsp_ctl_t ctl,
    input  logic [7:0]         instr_q [4],
    input  logic [7:0]         data_q  [4],
    output ecmm_pkg::mem_rsp_t rsp
);

    logic [31:0] gathered;

    // Byte i of the span comes from bank (lane + i) and lands right aligned.
    always_comb begin
        logic [1:0] pos;
        logic [1:0] shift_k;
        gathered = 32'd0;
        for (int i = 0; i < 4; i++) begin
            pos     = ctl.lane + 2'(i);
            shift_k = 2'(ctl.count - 3'd1 - 3'(i));
            if (3'(i) < ctl.count) begin
                gathered[{shift_k, 3'b000} +: 8] =
                    (ctl.kind == ecmm_pkg::ACC_INSTR_RD) ? instr_q[pos] : data_q[pos];
            end
        end
    end

    // Result fields by access outcome.
    always_comb begin
        rsp = '0;
        case (ctl.kind)
            ecmm_pkg::ACC_FAULT: begin
                rsp.fault = 1'b1;
            end
            ecmm_pkg::ACC_CON_IN: begin
                rsp.read_data        = {24'd0, ctl.con_byte};
                rsp.console_in_taken = 1'b1;
            end
            ecmm_pkg::ACC_CON_END: begin
                rsp.read_data = '1;
            end
            ecmm_pkg::ACC_CON_OUT: begin
                rsp.console_out_valid = 1'b1;
                rsp.console_out_byte  = ctl.con_byte;
            end
            ecmm_pkg::ACC_DATA_RD, ecmm_pkg::ACC_INSTR_RD: begin
                rsp.read_data = gathered;
            end
            default: begin
                rsp = '0;
            end
        endcase
    end

endmodule

FILE: src/emulated_cpu_memory_map.sv
// Emulated processor memory map: big-endian byte memory with instruction
// and data regions in byte banks. Depends on ecmm_pkg, ecmm_ram,
// ecmm_decode and ecmm_assemble.
//
// Usage: each word on the s_ channel is one access (data read, data write,
// instruction fetch or program word load); each access gives exactly one
// result word on the m_ channel, in order. Both channels use valid/ready.
// The cfg_ port writes a register at any edge with cfg_we high; write it
// only while no access is in flight.
// Pipeline: an accepted access is taken by the input register, then its banks
// are accessed as it moves into the response stage, and its result word is
// loaded into the output register. Throughput: one access per cycle while
// m_ready allows, set by the single port of each of the four byte banks per
// store; every access touches each bank at most once.
// Reset: aresetn low clears the pipeline and restores the register reset
// values. A clearing pass then zeroes both stores one row of four bytes
// per cycle, sweeping 2^(max(INSTR_BYTES_LOG2, DATA_BYTES_LOG2) - 2) rows
// (16384 by default); s_ready stays low meanwhile.
// Stall: when m_ready is low the result holds in the output register, one
// more access may wait in the response stage and another in the input
// register; s_ready then drops until the stall clears.
`timescale 1ns / 1ps

module emulated_cpu_memory_map #(
    parameter int INSTR_BYTES_LOG2 = 16,
    parameter int DATA_BYTES_LOG2  = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ecmm_pkg::mem_req_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ecmm_pkg::mem_rsp_t                  m_data,
    input  logic                                cfg_we,
    input  logic [ecmm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [31:0]                         cfg_wdata
);

    localparam int IROW_W = INSTR_BYTES_LOG2 - 2;
    localparam int DROW_W = DATA_BYTES_LOG2 - 2;
    localparam int CLR_W  = (IROW_W > DROW_W) ? IROW_W : DROW_W;

    ecmm_pkg::cfg_t     cfg_reg, cfg_next;
    logic               clear_reg, clear_next;
    logic [CLR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic               req_valid_reg, req_valid_next;
    ecmm_pkg::mem_req_t req_reg, req_next;
    logic               rsp_valid_reg, rsp_valid_next;
    ecmm_pkg::rsp_ctl_t rsp_ctl_reg, rsp_ctl_next;
    logic               out_valid_reg, out_valid_next;
    ecmm_pkg::mem_rsp_t out_reg, out_next;

    logic               out_free;
    logic               rsp_free;
    logic               issue;
    logic               accept;

    logic [IROW_W-1:0]  instr_row [4];
    logic [DROW_W-1:0]  data_row  [4];
    logic [7:0]         bank_byte [4];
    logic [3:0]         instr_we;
    logic [3:0]         data_we;
    logic               instr_re;
    logic               data_re;
    ecmm_pkg::rsp_ctl_t dec_ctl;
    logic [7:0]         instr_q [4];
    logic [7:0]         data_q  [4];
    ecmm_pkg::mem_rsp_t asm_rsp;

    // Pipeline flow: each stage moves when the one after it has room.
    assign out_free = !out_valid_reg || m_ready;
    assign rsp_free = !rsp_valid_reg || out_free;
    assign issue    = req_valid_reg && rsp_free;
    assign s_ready  = !clear_reg && (!req_valid_reg || rsp_free);
    assign accept   = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    // Configuration register writes.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                ecmm_pkg::CFG_INSTR_BASE:  cfg_next.instr_base  = cfg_wdata;
                ecmm_pkg::CFG_DATA_BASE:   cfg_next.data_base   = cfg_wdata;
                ecmm_pkg::CFG_GETC_BASE:   cfg_next.getc_base   = cfg_wdata;
                ecmm_pkg::CFG_PUTC_BASE:   cfg_next.putc_base   = cfg_wdata;
                ecmm_pkg::CFG_PORT_WINDOW: cfg_next.port_window = cfg_wdata[4:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    // Clearing pass sweeps every row after reset, each row of the deeper store once.
    always_comb begin
        clear_next   = clear_reg;
        clr_cnt_next = clr_cnt_reg;
        if (clear_reg) begin
            clr_cnt_next = clr_cnt_reg + CLR_W'(1);
            if (clr_cnt_reg == {CLR_W{1'b1}}) begin
                clear_next = 1'b0;
            end
        end
    end

    // Stage registers: input word, issued access, finished result.
    always_comb begin
        req_valid_next = req_valid_reg;
        req_next       = req_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_ctl_next   = rsp_ctl_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (accept) begin
            req_valid_next = 1'b1;
            req_next       = s_data;
        end else if (issue) begin
            req_valid_next = 1'b0;
        end
        if (rsp_free) begin
            rsp_valid_next = issue;
            rsp_ctl_next   = dec_ctl;
        end
        if (out_free) begin
            out_valid_next = rsp_valid_reg;
            out_next       = asm_rsp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.instr_base  <= ecmm_pkg::RST_INSTR_BASE;
            cfg_reg.data_base   <= ecmm_pkg::RST_DATA_BASE;
            cfg_reg.getc_base   <= ecmm_pkg::RST_GETC_BASE;
            cfg_reg.putc_base   <= ecmm_pkg::RST_PUTC_BASE;
            cfg_reg.port_window <= ecmm_pkg::RST_PORT_WINDOW;
            clear_reg           <= 1'b1;
            clr_cnt_reg         <= '0;
            req_valid_reg       <= 1'b0;
            rsp_valid_reg       <= 1'b0;
            out_valid_reg       <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            clear_reg     <= clear_next;
            clr_cnt_reg   <= clr_cnt_next;
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        rsp_ctl_reg <= rsp_ctl_next;
        out_reg     <= out_next;
    end

    ecmm_decode #(
        .INSTR_BYTES_LOG2 (INSTR_BYTES_LOG2),
        .DATA_BYTES_LOG2  (DATA_BYTES_LOG2)
    ) u_decode (
        .req       (req_reg),
        .cfg       (cfg_reg),
        .instr_row (instr_row),
        .data_row  (data_row),
        .bank_byte (bank_byte),
        .instr_we  (instr_we),
        .data_we   (data_we),
        .instr_re  (instr_re),
        .data_re   (data_re),
        .ctl       (dec_ctl)
    );

    // Four byte banks per store; the clearing pass owns them after reset.
    for (genvar b = 0; b < 4; b++) begin : g_bank
        ecmm_ram #(
            .WIDTH (8),
            .DEPTH (2 ** IROW_W)
        ) u_instr_bank (
            .clk   (aclk),
            .we    (clear_reg || (issue && instr_we[b])),
            .re    (issue && instr_re),
            .addr  (clear_reg ? clr_cnt_reg[IROW_W-1:0] : instr_row[b]),
            .wdata (clear_reg ? 8'h00 : bank_byte[b]),
            .rdata (instr_q[b])
        );

        ecmm_ram #(
            .WIDTH (8),
            .DEPTH (2 ** DROW_W)
        ) u_data_bank (
            .clk   (aclk),
            .we    (clear_reg || (issue && data_we[b])),
            .re    (issue && data_re),
            .addr  (clear_reg ? clr_cnt_reg[DROW_W-1:0] : data_row[b]),
            .wdata (clear_reg ? 8'h00 : bank_byte[b]),
            .rdata (data_q[b])
        );
    end

    ecmm_assemble u_assemble (
        .ctl     (rsp_ctl_reg),
        .instr_q (instr_q),
        .data_q  (data_q),
        .rsp     (asm_rsp)
    );

endmodule

FILE: src/ecmm_checker.sv
// Port-level checker for the emulated memory map, bound to the top level.
// Depends on ecmm_pkg and emulated_cpu_memory_map_defines.svh.
`timescale 1ns / 1ps
`include "emulated_cpu_memory_map_defines.svh"

module ecmm_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input ecmm_pkg::mem_rsp_t m_data
);

    // A stalled result holds its word.
    `ECMM_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data))

    // A faulting access reports nothing else.
    `ECMM_ASSERT(a_fault_quiet, aclk, aresetn, m_valid && m_data.fault |-> m_data.read_data == 32'd0 && !m_data.console_in_taken && !m_data.console_out_valid)

    // A consumed console byte is returned zero-extended on a read.
    `ECMM_ASSERT(a_taken_byte, aclk, aresetn, m_valid && m_data.console_in_taken |-> m_data.read_data[31:8] == 24'd0 && !m_data.console_out_valid)

    // The output byte is zero unless a console byte is emitted.
    `ECMM_ASSERT(a_out_byte, aclk, aresetn, m_valid && !m_data.console_out_valid |-> m_data.console_out_byte == 8'd0)

    // Reset empties the pipeline and starts the clearing pass.
    `ECMM_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid && !s_ready)

endmodule

bind emulated_cpu_memory_map ecmm_checker u_ecmm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
